>>> hw/rtl/rars_pkg.sv
// ----------------------------------------------------------------------------
// rars_pkg: shared types and constants of the range-add / range-sum tree
// Holds the field widths, the controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rars_pkg;

    localparam int IDX_W         = 11;
    localparam int VAL_W         = 64;
    localparam int DEF_MAX_ELEMS = 1024;
    localparam logic [IDX_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_POP, ST_EVAL,
        ST_QRD, ST_QACC, ST_PRD, ST_PCHK,
        ST_GMUL_LO, ST_GMUL_HI, ST_GWR, ST_PCLR,
        ST_PUSH_FIX, ST_PUSH_RIGHT, ST_PUSH_LEFT,
        ST_FIX_LEFT, ST_FIX_RIGHT, ST_FIX_WR, ST_OUT
    } state_t;

    typedef enum logic [1:0] {RD_CUR, RD_LEFT, RD_RIGHT, RD_TGT} rd_sel_t;
    typedef enum logic [1:0] {TGT_SELF, TGT_LEFT, TGT_RIGHT} give_sel_t;
    typedef enum logic [1:0] {PUSH_NONE, PUSH_FIX, PUSH_RIGHT, PUSH_LEFT} push_t;

    typedef struct packed {
        logic      load_req;
        logic      pop;
        push_t     push;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      set_tgt;
        give_sel_t tgt_sel;
        logic      mul_lo;
        logic      mul_hi;
        logic      give_wr;
        logic      latch_tmp;
        logic      fix_wr;
        logic      pclr_wr;
        logic      acc_add;
        logic      emit;
        logic      clr_start;
        logic      clr_step;
    } cmd_t;

    typedef struct packed {
        logic sp_empty;
        logic cur_fix;
        logic cur_disjoint;
        logic cur_cover;
        logic is_query;
        logic req_empty;
        logic pend_zero;
        logic clr_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/rars_ctrl.sv
// ----------------------------------------------------------------------------
// rars_ctrl: request sequencer
// Walks the tree one micro-step per cycle and drives the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rars_ctrl
    import rars_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic    cfg_we,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t    state_reg, state_next;
    give_sel_t give_sel_reg, give_sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            give_sel_reg <= TGT_SELF;
        end else begin
            state_reg    <= state_next;
            give_sel_reg <= give_sel_next;
        end
    end

    // Next state.
    always_comb begin
        state_next    = state_reg;
        give_sel_next = give_sel_reg;
        unique case (state_reg)
            ST_CLEAR:   if (status.clr_done) state_next = ST_IDLE;
            ST_IDLE:    if (s_tvalid) state_next = ST_START;
            ST_START: begin
                if (status.req_empty)
                    state_next = status.is_query ? ST_OUT : ST_IDLE;
                else
                    state_next = ST_POP;
            end
            ST_POP: begin
                if (status.sp_empty)
                    state_next = status.is_query ? ST_OUT : ST_IDLE;
                else
                    state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.cur_fix) begin
                    state_next = ST_FIX_LEFT;
                end else if (status.cur_disjoint) begin
                    state_next = ST_POP;
                end else if (status.cur_cover) begin
                    if (status.is_query) begin
                        state_next = ST_QRD;
                    end else begin
                        state_next    = ST_GMUL_LO;
                        give_sel_next = TGT_SELF;
                    end
                end else begin
                    state_next = ST_PRD;
                end
            end
            ST_QRD:     state_next = ST_QACC;
            ST_QACC:    state_next = ST_POP;
            ST_PRD:     state_next = ST_PCHK;
            ST_PCHK: begin
                if (status.pend_zero) begin
                    state_next = status.is_query ? ST_PUSH_RIGHT : ST_PUSH_FIX;
                end else begin
                    state_next    = ST_GMUL_LO;
                    give_sel_next = TGT_LEFT;
                end
            end
            ST_GMUL_LO: state_next = ST_GMUL_HI;
            ST_GMUL_HI: state_next = ST_GWR;
            ST_GWR: begin
                unique case (give_sel_reg)
                    TGT_LEFT: begin
                        state_next    = ST_GMUL_LO;
                        give_sel_next = TGT_RIGHT;
                    end
                    TGT_RIGHT: state_next = ST_PCLR;
                    default:   state_next = ST_POP;
                endcase
            end
            ST_PCLR:       state_next = status.is_query ? ST_PUSH_RIGHT : ST_PUSH_FIX;
            ST_PUSH_FIX:   state_next = ST_PUSH_RIGHT;
            ST_PUSH_RIGHT: state_next = ST_PUSH_LEFT;
            ST_PUSH_LEFT:  state_next = ST_POP;
            ST_FIX_LEFT:   state_next = ST_FIX_RIGHT;
            ST_FIX_RIGHT:  state_next = ST_FIX_WR;
            ST_FIX_WR:     state_next = ST_POP;
            ST_OUT:        if (!status.out_busy) state_next = ST_IDLE;
            default:       state_next = ST_CLEAR;
        endcase
        if (cfg_we) state_next = ST_CLEAR;
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE: begin
                s_tready     = !cfg_we;
                cmd.load_req = s_tvalid && !cfg_we;
            end
            ST_POP:  cmd.pop = !status.sp_empty;
            ST_EVAL: begin
                if (!status.cur_fix && !status.cur_disjoint && status.cur_cover
                    && !status.is_query) begin
                    cmd.set_tgt = 1'b1;
                    cmd.tgt_sel = TGT_SELF;
                end
            end
            ST_QRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
            end
            ST_QACC: cmd.acc_add = 1'b1;
            ST_PRD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
            end
            ST_PCHK: begin
                if (!status.pend_zero) begin
                    cmd.set_tgt = 1'b1;
                    cmd.tgt_sel = TGT_LEFT;
                end
            end
            ST_GMUL_LO: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_TGT;
                cmd.mul_lo = 1'b1;
            end
            ST_GMUL_HI: cmd.mul_hi = 1'b1;
            ST_GWR: begin
                cmd.give_wr = 1'b1;
                if (give_sel_reg == TGT_LEFT) begin
                    cmd.set_tgt = 1'b1;
                    cmd.tgt_sel = TGT_RIGHT;
                end
            end
            ST_PCLR:       cmd.pclr_wr = 1'b1;
            ST_PUSH_FIX:   cmd.push = PUSH_FIX;
            ST_PUSH_RIGHT: cmd.push = PUSH_RIGHT;
            ST_PUSH_LEFT:  cmd.push = PUSH_LEFT;
            ST_FIX_LEFT: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LEFT;
            end
            ST_FIX_RIGHT: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_RIGHT;
                cmd.latch_tmp = 1'b1;
            end
            ST_FIX_WR: cmd.fix_wr = 1'b1;
            ST_OUT:    cmd.emit = !status.out_busy;
            default:   cmd = '0;
        endcase
        if (cfg_we) begin
            cmd           = '0;
            cmd.clr_start = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rars_dpath.sv
// ----------------------------------------------------------------------------
// rars_dpath: tree datapath
// Node sum and pending-mark memories, the walk stack, the mark multiplier,
// the query accumulator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rars_dpath
    import rars_pkg::*;
#(
    parameter int MAX_ELEMS = DEF_MAX_ELEMS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    output status_t               status,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_wdata,
    input  wire logic             req_type,
    input  wire logic [IDX_W-1:0] range_low,
    input  wire logic [IDX_W-1:0] range_high,
    input  wire logic [VAL_W-1:0] add_value,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    output logic [VAL_W-1:0]      m_tdata
);

    localparam int EW_RAW    = $clog2(MAX_ELEMS + 1);
    localparam int EW        = (EW_RAW > IDX_W) ? EW_RAW : IDX_W;
    localparam int MEM_DEPTH = 4 * MAX_ELEMS;
    localparam int NODE_W    = $clog2(MEM_DEPTH);
    localparam int STK_DEPTH = 2 ** $clog2(2 * $clog2(MAX_ELEMS) + 6);
    localparam int STK_IW    = $clog2(STK_DEPTH);
    localparam int SP_W      = STK_IW + 1;
    localparam int PW        = 32 + EW;
    localparam logic [EW-1:0] MAX_E = EW'(MAX_ELEMS);
    localparam logic [EW-1:0] ONE_E = EW'(1);

    // Configuration and request.
    logic [IDX_W-1:0] cfg_reg;
    logic [EW-1:0]    cfg_e, n_elems, a_in, b_in;
    logic [EW-1:0]    a_reg, b_reg;
    logic             query_reg;
    logic [VAL_W-1:0] amt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) cfg_reg <= CFG_RESET;
        else if (cfg_we) cfg_reg <= cfg_wdata;
    end

    always_comb begin
        cfg_e   = EW'(cfg_reg);
        n_elems = cfg_e;
        if (cfg_e == '0) n_elems = ONE_E;
        if (cfg_e > MAX_E) n_elems = MAX_E;
        a_in = EW'(range_low);
        if (a_in == '0) a_in = ONE_E;
        b_in = EW'(range_high);
        if (b_in > n_elems) b_in = n_elems;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            a_reg     <= a_in;
            b_reg     <= b_in;
            query_reg <= req_type;
            amt_reg   <= add_value;
        end
    end

    // Walk stack: each entry is a node to visit or a parent sum to refresh.
    logic              stk_fix  [STK_DEPTH];
    logic [NODE_W-1:0] stk_node [STK_DEPTH];
    logic [EW-1:0]     stk_lo   [STK_DEPTH];
    logic [EW-1:0]     stk_hi   [STK_DEPTH];
    logic [SP_W-1:0]   sp_reg;
    logic [STK_IW-1:0] top_idx, wr_idx;

    logic              cur_fix_reg;
    logic [NODE_W-1:0] cur_node_reg;
    logic [EW-1:0]     cur_lo_reg, cur_hi_reg;
    logic [EW-1:0]     split;
    logic [NODE_W-1:0] left_node, right_node;

    assign top_idx    = STK_IW'(sp_reg - SP_W'(1));
    assign wr_idx     = sp_reg[STK_IW-1:0];
    assign split      = cur_lo_reg + ((cur_hi_reg - cur_lo_reg) >> 1);
    assign left_node  = {cur_node_reg[NODE_W-2:0], 1'b0};
    assign right_node = {cur_node_reg[NODE_W-2:0], 1'b1};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (cmd.load_req) begin
            sp_reg <= SP_W'(1);
        end else if (cmd.pop) begin
            sp_reg <= sp_reg - SP_W'(1);
        end else if (cmd.push != PUSH_NONE) begin
            sp_reg <= sp_reg + SP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            stk_fix[0]  <= 1'b0;
            stk_node[0] <= NODE_W'(1);
            stk_lo[0]   <= ONE_E;
            stk_hi[0]   <= n_elems;
        end else begin
            case (cmd.push)
                PUSH_FIX: begin
                    stk_fix[wr_idx]  <= 1'b1;
                    stk_node[wr_idx] <= cur_node_reg;
                    stk_lo[wr_idx]   <= cur_lo_reg;
                    stk_hi[wr_idx]   <= cur_hi_reg;
                end
                PUSH_RIGHT: begin
                    stk_fix[wr_idx]  <= 1'b0;
                    stk_node[wr_idx] <= right_node;
                    stk_lo[wr_idx]   <= split + ONE_E;
                    stk_hi[wr_idx]   <= cur_hi_reg;
                end
                PUSH_LEFT: begin
                    stk_fix[wr_idx]  <= 1'b0;
                    stk_node[wr_idx] <= left_node;
                    stk_lo[wr_idx]   <= cur_lo_reg;
                    stk_hi[wr_idx]   <= split;
                end
                default: ;
            endcase
        end
        if (cmd.pop) begin
            cur_fix_reg  <= stk_fix[top_idx];
            cur_node_reg <= stk_node[top_idx];
            cur_lo_reg   <= stk_lo[top_idx];
            cur_hi_reg   <= stk_hi[top_idx];
        end
    end

    // Target of a mark application: the node itself or one of its children.
    logic [NODE_W-1:0] tgt_node_reg;
    logic [EW-1:0]     tgt_len_reg;
    logic [VAL_W-1:0]  tgt_amt_reg, mark_reg;
    logic [VAL_W-1:0]  rd_sum_reg, rd_pend_reg;

    always_ff @(posedge aclk) begin
        if (cmd.set_tgt) begin
            case (cmd.tgt_sel)
                TGT_LEFT: begin
                    tgt_node_reg <= left_node;
                    tgt_len_reg  <= split - cur_lo_reg + ONE_E;
                    tgt_amt_reg  <= rd_pend_reg;
                    mark_reg     <= rd_pend_reg;
                end
                TGT_RIGHT: begin
                    tgt_node_reg <= right_node;
                    tgt_len_reg  <= cur_hi_reg - split;
                    tgt_amt_reg  <= mark_reg;
                end
                default: begin
                    tgt_node_reg <= cur_node_reg;
                    tgt_len_reg  <= cur_hi_reg - cur_lo_reg + ONE_E;
                    tgt_amt_reg  <= amt_reg;
                end
            endcase
        end
    end

    // Mark times span length, modulo 2^64, in two 32-bit halves.
    logic [PW-1:0]    p_lo, p_hi;
    logic [VAL_W-1:0] plo_reg, prod_reg;

    assign p_lo = tgt_amt_reg[31:0] * tgt_len_reg;
    assign p_hi = tgt_amt_reg[63:32] * tgt_len_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_lo) plo_reg <= VAL_W'(p_lo);
        if (cmd.mul_hi) prod_reg <= plo_reg + {p_hi[31:0], 32'b0};
    end

    // Node memories.
    logic [VAL_W-1:0]  sum_mem  [MEM_DEPTH];
    logic [VAL_W-1:0]  pend_mem [MEM_DEPTH];
    logic [NODE_W-1:0] rd_addr, wr_addr, clr_cnt_reg;
    logic              sum_we, pend_we;
    logic [VAL_W-1:0]  sum_wdata, pend_wdata, tmp_reg;

    always_comb begin
        case (cmd.rd_sel)
            RD_LEFT:  rd_addr = left_node;
            RD_RIGHT: rd_addr = right_node;
            RD_TGT:   rd_addr = tgt_node_reg;
            default:  rd_addr = cur_node_reg;
        endcase
    end

    always_comb begin
        sum_we     = cmd.clr_step || cmd.give_wr || cmd.fix_wr;
        pend_we    = cmd.clr_step || cmd.give_wr || cmd.pclr_wr;
        wr_addr    = cur_node_reg;
        sum_wdata  = tmp_reg + rd_sum_reg;
        pend_wdata = '0;
        if (cmd.clr_step) begin
            wr_addr   = clr_cnt_reg;
            sum_wdata = '0;
        end else if (cmd.give_wr) begin
            wr_addr    = tgt_node_reg;
            sum_wdata  = rd_sum_reg + prod_reg;
            pend_wdata = rd_pend_reg + tgt_amt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_we) sum_mem[wr_addr] <= sum_wdata;
        if (pend_we) pend_mem[wr_addr] <= pend_wdata;
        if (cmd.rd_en) begin
            rd_sum_reg  <= sum_mem[rd_addr];
            rd_pend_reg <= pend_mem[rd_addr];
        end
        if (cmd.latch_tmp) tmp_reg <= rd_sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) clr_cnt_reg <= '0;
        else if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
    end

    // Query accumulator and output register.
    logic [VAL_W-1:0] acc_reg;
    logic             m_valid_reg;
    logic [VAL_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) acc_reg <= '0;
        else if (cmd.acc_add) acc_reg <= acc_reg + rd_sum_reg;
        if (cmd.emit) m_data_reg <= acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (cmd.emit) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        status.sp_empty     = (sp_reg == '0);
        status.cur_fix      = cur_fix_reg;
        status.cur_disjoint = (b_reg < cur_lo_reg) || (a_reg > cur_hi_reg);
        status.cur_cover    = (a_reg <= cur_lo_reg) && (b_reg >= cur_hi_reg);
        status.is_query     = query_reg;
        status.req_empty    = (a_reg > b_reg);
        status.pend_zero    = (rd_pend_reg == '0);
        status.clr_done     = (clr_cnt_reg == NODE_W'(MEM_DEPTH - 1));
        status.out_busy     = m_valid_reg && !m_tready;
    end

endmodule

`default_nettype wire

>>> hw/rtl/range_add_range_sum_tree_top.sv
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top: range-add / range-sum segment tree
// Lazy-propagation segment tree over up to MAX_ELEMS signed 64-bit elements.
// ----------------------------------------------------------------------------
// The block keeps a segment tree of node sums with pending-add marks over
// elements 1..n, where n is the configured element count clamped to
// 1..MAX_ELEMS. An input beat with s_tuser low adds add_value to every element
// in [range_low, range_high] and returns nothing; a beat with s_tuser high
// returns one output beat with the wrapping 64-bit sum over that range. The
// low bound is raised to 1 and the high bound lowered to n; an empty range
// adds nothing and sums to zero. Requests are handled one at a time: the walk
// runs through a single-port node memory pair, one micro-step per cycle. Each
// node visited is passed over, summed whole, marked whole or split; a node
// split on an add has its sum refreshed afterwards, and a split node whose
// pending mark is set first pushes that mark to its children. A query ends
// by waiting for the output register to free up. A typical request touches
// roughly four nodes per tree level. A new request is taken while an earlier
// result still waits on the output. After reset and after every write of the
// element count the tree is cleared by a pass over all 4 * MAX_ELEMS node
// slots, during which s_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_range_sum_tree_top
    import rars_pkg::*;
#(
    parameter int MAX_ELEMS = DEF_MAX_ELEMS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // Element count register.
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_wdata,
    // Request stream.
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [87:0]      s_tdata,   // range_low, range_high, add_value, zero pad
    input  wire logic             s_tuser,   // req_type
    // Result stream.
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [VAL_W-1:0]      m_tdata    // range_sum
);

    cmd_t    cmd;
    status_t status;

    rars_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cfg_we   (cfg_we),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns the tree memories, the walk stack and the result
    // register; the controller only sequences it.
    rars_dpath #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_type   (s_tuser),
        .range_low  (s_tdata[10:0]),
        .range_high (s_tdata[21:11]),
        .add_value  (s_tdata[85:22]),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/rars_checker.sv
// ----------------------------------------------------------------------------
// rars_checker: port-level checks of the range-add / range-sum tree
// Watches the top-level ports and is bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module rars_checker
    import rars_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             cfg_we,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [VAL_W-1:0] m_tdata
);

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A write of the element count starts the clearing pass.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("request taken right after an element count write");

    // Requests are handled one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    // A result only appears while no request is being taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

endmodule

bind range_add_range_sum_tree_top rars_checker u_rars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> sim/range_add_range_sum_tree_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_top_test: self-checking bench for the range tree
// Drives add and query beats into the block and keeps its own lazy segment
// tree. Results are compared with a table sum or the sum predicted at acceptance.
// ----------------------------------------------------------------------------
// The run starts with a directed table at the reset element count, then walks
// through several element counts, including the clamped extremes. Every
// element count write clears the tree, so the local copy is cleared as well.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the request side backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module range_add_range_sum_tree_top_test;
    import rars_pkg::*;

    localparam int NODE_SLOTS  = 4 * DEF_MAX_ELEMS + 4;
    // Cycles allowed for an add to finish, since it returns no result beat.
    localparam int DRAIN_WAIT  = 3000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [87:0]      s_tdata = '0;   // range_low, range_high, add_value, zero pad
    logic             s_tuser = 1'b0; // req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [VAL_W-1:0] m_tdata;        // range_sum

    // Local copy of the tree and its pending-add marks.
    logic [63:0] node_total [NODE_SLOTS];
    logic [63:0] node_owed  [NODE_SLOTS];
    int unsigned elem_count;

    logic [63:0] sums_due [$];
    int          error_count = 0;
    int          results_seen = 0;
    bit          no_idle = 1'b0;

    typedef struct {
        logic        kind;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [63:0] amount;
        bit          has_lit;
        logic [63:0] lit_sum;
    } table_row_t;

    range_add_range_sum_tree_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor: lazy segment tree, node 1 is the root, children 2i, 2i+1.
    // ------------------------------------------------------------------
    function automatic void clear_tree(input logic [10:0] count_reg);
        for (int i = 0; i < NODE_SLOTS; i++) begin
            node_total[i] = '0;
            node_owed[i]  = '0;
        end
        elem_count = 32'(count_reg);
        if (elem_count < 1) elem_count = 1;
        if (elem_count > DEF_MAX_ELEMS) elem_count = DEF_MAX_ELEMS;
    endfunction

    function automatic void mark_node(input int unsigned at, input int unsigned lo,
                                      input int unsigned hi, input logic [63:0] amt);
        logic [63:0] width;
        if (at >= NODE_SLOTS) return;
        width = 64'(hi - lo + 1);
        node_total[at] += amt * width;
        node_owed[at]  += amt;
    endfunction

    function automatic void push_down(input int unsigned at, input int unsigned lo,
                                      input int unsigned hi);
        int unsigned mid;
        mid = lo + (hi - lo) / 2;
        if (at >= NODE_SLOTS || node_owed[at] == 64'd0) return;
        mark_node(2 * at, lo, mid, node_owed[at]);
        mark_node(2 * at + 1, mid + 1, hi, node_owed[at]);
        node_owed[at] = '0;
    endfunction

    function automatic void tree_add(input int unsigned at, input int unsigned lo,
                                     input int unsigned hi, input int unsigned a,
                                     input int unsigned b, input logic [63:0] amt);
        int unsigned mid;
        if (at >= NODE_SLOTS || b < lo || a > hi) return;
        if (a <= lo && b >= hi) begin
            mark_node(at, lo, hi, amt);
            return;
        end
        mid = lo + (hi - lo) / 2;
        push_down(at, lo, hi);
        tree_add(2 * at, lo, mid, a, b, amt);
        tree_add(2 * at + 1, mid + 1, hi, a, b, amt);
        if (2 * at + 1 < NODE_SLOTS)
            node_total[at] = node_total[2 * at] + node_total[2 * at + 1];
    endfunction

    function automatic logic [63:0] tree_sum(input int unsigned at, input int unsigned lo,
                                             input int unsigned hi, input int unsigned a,
                                             input int unsigned b);
        int unsigned mid;
        if (at >= NODE_SLOTS || b < lo || a > hi) return '0;
        if (a <= lo && b >= hi) return node_total[at];
        mid = lo + (hi - lo) / 2;
        push_down(at, lo, hi);
        return tree_sum(2 * at, lo, mid, a, b) + tree_sum(2 * at + 1, mid + 1, hi, a, b);
    endfunction

    // Applies one accepted request; returns the predicted sum for a query.
    function automatic logic [63:0] apply_request(input logic kind, input logic [10:0] lo,
                                                  input logic [10:0] hi,
                                                  input logic [63:0] amt);
        int unsigned a;
        int unsigned b;
        a = 32'(lo);
        b = 32'(hi);
        if (a < 1) a = 1;
        if (b > elem_count) b = elem_count;
        if (kind == REQ_ADD) begin
            if (a <= b) tree_add(1, 1, elem_count, a, b, amt);
            return '0;
        end
        return (a <= b) ? tree_sum(1, 1, elem_count, a, b) : 64'd0;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Request side. The predictor runs at the edge where the beat is taken,
    // so the order of expectations follows the order of acceptance.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic kind, input logic [10:0] lo, input logic [10:0] hi,
                             input logic [63:0] amt, input bit has_lit,
                             input logic [63:0] lit_sum);
        int          gap;
        logic [63:0] predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, amt, hi, lo};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(kind, lo, hi, amt);
        if (kind == REQ_QUERY) sums_due.push_back(has_lit ? lit_sum : predicted);
    endtask

    // Waits until the block is idle, then writes the element count.
    task automatic write_count(input logic [10:0] value);
        s_tvalid <= 1'b0;
        wait (sums_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        clear_tree(value);
    endtask

    task automatic random_beat();
        logic        kind;
        logic [10:0] lo;
        logic [10:0] hi;
        logic [63:0] amt;
        int          pick;
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 85) begin
            lo = 11'($urandom_range(1, elem_count));
            hi = 11'($urandom_range(32'(lo), elem_count));
        end else begin
            lo = 11'($urandom_range(0, 2047));
            hi = 11'($urandom_range(0, 2047));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)      amt = 64'($signed($urandom_range(0, 200)) - 100);
        else if (pick < 8) amt = {$urandom, $urandom};
        else if (pick < 9) amt = 64'h7FFF_FFFF_FFFF_FFFF;
        else               amt = 64'h8000_0000_0000_0000;
        send_beat(kind, lo, hi, amt, 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off after a few dozen
    // results while the request side keeps offering beats.
    // ------------------------------------------------------------------
    initial begin : result_stall
        int  gap;
        bit  held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= 40) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Every result beat is compared with the oldest outstanding sum.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (sums_due.size() == 0) begin
                $error("range_sum: unexpected beat, actual %0d", $signed(m_tdata));
                error_count++;
            end else begin
                if (m_tdata !== sums_due[0]) begin
                    $error("range_sum mismatch: expected %0d, actual %0d",
                           $signed(sums_due[0]), $signed(m_tdata));
                    error_count++;
                end
                void'(sums_due.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : main_seq
        table_row_t  rows [$];
        logic [10:0] counts [8];
        int          beats [8];
        rows = '{
            '{REQ_QUERY, 11'd1,    11'd1024, 64'd0, 1'b1, 64'd0},
            '{REQ_ADD,   11'd1,    11'd1024, 64'd1, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd1,    11'd1024, 64'd0, 1'b1, 64'd1024},
            '{REQ_ADD,   11'd3,    11'd3,    64'd5, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd3,    11'd3,    64'd0, 1'b1, 64'd6},
            // Bounds outside the element count are clipped.
            '{REQ_QUERY, 11'd0,    11'd2047, 64'd0, 1'b1, 64'd1029},
            // An empty range adds nothing and sums to zero.
            '{REQ_ADD,   11'd10,   11'd9,    64'd7, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd10,   11'd9,    64'd0, 1'b1, 64'd0},
            '{REQ_QUERY, 11'd1,    11'd1024, 64'd0, 1'b1, 64'd1029},
            // Largest and smallest amounts, wrapping sums.
            '{REQ_ADD,   11'd1,    11'd1,    64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd1,    11'd2,    64'd0, 1'b0, 64'd0},
            '{REQ_ADD,   11'd1024, 11'd1024, 64'h8000_0000_0000_0000, 1'b0, 64'd0},
            '{REQ_ADD,   11'd2047, 11'd0,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
            '{REQ_ADD,   11'd500,  11'd700,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd512,  11'd1024, 64'd0, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd1,    11'd1024, 64'd0, 1'b0, 64'd0},
            '{REQ_QUERY, 11'd1,    11'd1,    64'd0, 1'b0, 64'd0}
        };
        // Zero and 2047 are clamped to one and to the largest count.
        counts = '{11'd0, 11'd2047, 11'd2, 11'd5, 11'd37, 11'd1024, 11'd300, 11'd1};
        beats  = '{30, 50, 60, 100, 120, 60, 110, 30};

        clear_tree(CFG_RESET);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i])
            send_beat(rows[i].kind, rows[i].lo, rows[i].hi, rows[i].amount,
                      rows[i].has_lit, rows[i].lit_sum);

        for (int p = 0; p < 8; p++) begin
            write_count(counts[p]);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < beats[p]; k++) random_beat();
        end
        s_tvalid <= 1'b0;

        wait (sums_due.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
